### hw/rtl/tmmb_pkg.sv
// shared types and constants for the trs model matrix builder
package tmmb_pkg;

  // matrix geometry
  localparam int unsigned NCOL    = 3;
  localparam int unsigned ROW_W   = 2;
  localparam logic [ROW_W-1:0] ROW_POS = 2'd3;

  // datapath widths
  localparam int unsigned QW   = 16;  // quaternion and scale fields
  localparam int unsigned PW   = 32;  // quaternion products, position, outputs
  localparam int unsigned MW   = 34;  // rotation entries, q.28
  localparam int unsigned SW   = MW + QW;  // scaled entries, q.36
  localparam int unsigned RSH  = 20;  // q.36 to q16.16

  localparam logic signed [MW-1:0] ONE_Q28  = 34'sd268435456;
  localparam logic signed [SW-1:0] HALF_LSB = 50'sd524288;
  localparam logic signed [SW-1:0] OUT_MAX  = 50'sd2147483647;
  localparam logic signed [SW-1:0] OUT_MIN  = -50'sd2147483648;
  localparam logic [PW-1:0]        ONE_Q16  = 32'h0001_0000;

  // how a column entry combines its two products
  typedef enum logic [1:0] {
    COP_DIAG = 2'd0,  // 1 - 2(p + q)
    COP_ADD  = 2'd1,  // 2(p + q)
    COP_SUB  = 2'd2   // 2(p - q)
  } cop_t;

endpackage

### hw/rtl/trs_model_matrix_builder_unit.sv
// trs model matrix builder: quaternion, scale and position to a 4x4 model matrix
// Each request carries one object transform (position q16.16, rotation quaternion q2.14,
// per-axis scale q8.8) and yields four row results in order 0..3. Rows 0-2 hold the
// rotation matrix of the quaternion (used as given, not normalised) scaled by
// scale_x/y/z, rounded half up to q16.16 and saturated, with column 3 zero. Row 3
// holds the position and 1.0; it carries matrix_done and, for the last transform of a
// batch, batch_done. The single result channel moves one row per cycle while out_ready
// is high, four rows per transform; a row sequencer feeds one row per cycle, when
// stage 1 can load, into a four-stage pipeline (product select and 16x16 multiply,
// combine, scale multiply, round and saturate) that follows the holding register.
// Stages compress bubbles under back-pressure, so a new transform is taken while
// earlier rows still wait at the output.
module trs_model_matrix_builder_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [tmmb_pkg::PW-1:0]   in_pos_x,
  input  logic signed [tmmb_pkg::PW-1:0]   in_pos_y,
  input  logic signed [tmmb_pkg::PW-1:0]   in_pos_z,
  input  logic signed [tmmb_pkg::QW-1:0]   in_quat_x,
  input  logic signed [tmmb_pkg::QW-1:0]   in_quat_y,
  input  logic signed [tmmb_pkg::QW-1:0]   in_quat_z,
  input  logic signed [tmmb_pkg::QW-1:0]   in_quat_w,
  input  logic signed [tmmb_pkg::QW-1:0]   in_scale_x,
  input  logic signed [tmmb_pkg::QW-1:0]   in_scale_y,
  input  logic signed [tmmb_pkg::QW-1:0]   in_scale_z,
  input  logic                             in_batch_end,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tmmb_pkg::ROW_W-1:0]       out_row_index,
  output logic signed [tmmb_pkg::PW-1:0]   out_col0,
  output logic signed [tmmb_pkg::PW-1:0]   out_col1,
  output logic signed [tmmb_pkg::PW-1:0]   out_col2,
  output logic signed [tmmb_pkg::PW-1:0]   out_col3,
  output logic                             out_matrix_done,
  output logic                             out_batch_done
);
  import tmmb_pkg::*;

  // ---------------------------------------------------------------------------
  // holding register: one transform, issued as four rows
  // ---------------------------------------------------------------------------
  logic                   hold_vld_r, hold_vld_nxt;
  logic [ROW_W-1:0]       row_cnt_r, row_cnt_nxt;
  logic signed [PW-1:0]   h_pos_r [NCOL];
  logic signed [QW-1:0]   h_qx_r, h_qy_r, h_qz_r, h_qw_r;
  logic signed [QW-1:0]   h_sc_r [NCOL];
  logic                   h_be_r;

  // stage 1: quaternion products
  logic                   s1_vld_r, s1_vld_nxt;
  logic [ROW_W-1:0]       s1_row_r;
  logic signed [PW-1:0]   s1_p_r [NCOL];
  logic signed [PW-1:0]   s1_q_r [NCOL];
  cop_t                   s1_op_r [NCOL];
  logic signed [QW-1:0]   s1_sc_r;
  logic                   s1_be_r;

  // stage 2: rotation entries, q.28
  logic                   s2_vld_r, s2_vld_nxt;
  logic [ROW_W-1:0]       s2_row_r;
  logic signed [MW-1:0]   s2_m_r [NCOL];
  logic signed [QW-1:0]   s2_sc_r;
  logic                   s2_be_r;

  // stage 3: scaled entries, q.36
  logic                   s3_vld_r, s3_vld_nxt;
  logic [ROW_W-1:0]       s3_row_r;
  logic signed [SW-1:0]   s3_s_r [NCOL];
  logic                   s3_be_r;

  // output register
  logic                   o_vld_r, o_vld_nxt;
  logic [ROW_W-1:0]       o_row_r;
  logic signed [PW-1:0]   o_col_r [NCOL];
  logic                   o_be_r;

  // stage loads: a stage takes new data when empty or when its content moves on
  logic o_ld, s3_ld, s2_ld, s1_ld, issue, in_acc;

  assign o_ld   = !o_vld_r  || out_ready;
  assign s3_ld  = !s3_vld_r || o_ld;
  assign s2_ld  = !s2_vld_r || s3_ld;
  assign s1_ld  = !s1_vld_r || s2_ld;
  assign issue  = hold_vld_r && s1_ld;
  // the last row leaving frees the holding register in the same cycle
  assign in_ready = !hold_vld_r || (issue && (row_cnt_r == ROW_POS));
  assign in_acc   = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // operand selection per row for the three column entries
  // ---------------------------------------------------------------------------
  logic signed [QW-1:0] opa [NCOL], opb [NCOL], opc [NCOL], opd [NCOL];
  cop_t                 sel_op [NCOL];
  logic signed [QW-1:0] sel_sc;
  logic signed [PW-1:0] prod_p [NCOL], prod_q [NCOL];

  always_comb begin
    for (int c = 0; c < NCOL; c++) begin
      opa[c]    = '0;
      opb[c]    = '0;
      opc[c]    = '0;
      opd[c]    = '0;
      sel_op[c] = COP_ADD;
    end
    sel_sc = '0;
    unique case (row_cnt_r)
      2'd0: begin
        sel_sc = h_sc_r[0];
        opa[0] = h_qy_r; opb[0] = h_qy_r; opc[0] = h_qz_r; opd[0] = h_qz_r; sel_op[0] = COP_DIAG;
        opa[1] = h_qx_r; opb[1] = h_qy_r; opc[1] = h_qw_r; opd[1] = h_qz_r; sel_op[1] = COP_ADD;
        opa[2] = h_qx_r; opb[2] = h_qz_r; opc[2] = h_qw_r; opd[2] = h_qy_r; sel_op[2] = COP_SUB;
      end
      2'd1: begin
        sel_sc = h_sc_r[1];
        opa[0] = h_qx_r; opb[0] = h_qy_r; opc[0] = h_qw_r; opd[0] = h_qz_r; sel_op[0] = COP_SUB;
        opa[1] = h_qx_r; opb[1] = h_qx_r; opc[1] = h_qz_r; opd[1] = h_qz_r; sel_op[1] = COP_DIAG;
        opa[2] = h_qy_r; opb[2] = h_qz_r; opc[2] = h_qw_r; opd[2] = h_qx_r; sel_op[2] = COP_ADD;
      end
      2'd2: begin
        sel_sc = h_sc_r[2];
        opa[0] = h_qx_r; opb[0] = h_qz_r; opc[0] = h_qw_r; opd[0] = h_qy_r; sel_op[0] = COP_ADD;
        opa[1] = h_qy_r; opb[1] = h_qz_r; opc[1] = h_qw_r; opd[1] = h_qx_r; sel_op[1] = COP_SUB;
        opa[2] = h_qx_r; opb[2] = h_qx_r; opc[2] = h_qy_r; opd[2] = h_qy_r; sel_op[2] = COP_DIAG;
      end
      default: begin
        // position row: products unused, position bypasses the datapath
      end
    endcase
  end

  always_comb begin
    for (int c = 0; c < NCOL; c++) begin
      prod_p[c] = opa[c] * opb[c];
      prod_q[c] = opc[c] * opd[c];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2 combine, stage 3 scale, output round and saturate
  // ---------------------------------------------------------------------------
  logic signed [MW-1:0] sum_m [NCOL], m_nxt [NCOL];
  logic signed [SW-1:0] s_nxt [NCOL];
  logic signed [SW-1:0] rnd [NCOL], shr [NCOL];
  logic signed [PW-1:0] col_nxt [NCOL];

  always_comb begin
    for (int c = 0; c < NCOL; c++) begin
      sum_m[c] = '0;
      m_nxt[c] = '0;
      if (s1_row_r == ROW_POS) begin
        m_nxt[c] = MW'(s1_p_r[c]);
      end else begin
        unique case (s1_op_r[c])
          COP_DIAG: begin
            sum_m[c] = MW'(s1_p_r[c]) + MW'(s1_q_r[c]);
            m_nxt[c] = ONE_Q28 - (sum_m[c] <<< 1);
          end
          COP_ADD: begin
            sum_m[c] = MW'(s1_p_r[c]) + MW'(s1_q_r[c]);
            m_nxt[c] = sum_m[c] <<< 1;
          end
          COP_SUB: begin
            sum_m[c] = MW'(s1_p_r[c]) - MW'(s1_q_r[c]);
            m_nxt[c] = sum_m[c] <<< 1;
          end
          default: begin
            m_nxt[c] = '0;
          end
        endcase
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NCOL; c++) begin
      if (s2_row_r == ROW_POS) s_nxt[c] = SW'(s2_m_r[c]);
      else                     s_nxt[c] = s2_m_r[c] * s2_sc_r;
    end
  end

  // add half an lsb, floor-shift to q16.16, clamp to 32 bits
  always_comb begin
    for (int c = 0; c < NCOL; c++) begin
      rnd[c] = s3_s_r[c] + HALF_LSB;
      shr[c] = rnd[c] >>> RSH;
      if (s3_row_r == ROW_POS)   col_nxt[c] = s3_s_r[c][PW-1:0];
      else if (shr[c] > OUT_MAX) col_nxt[c] = OUT_MAX[PW-1:0];
      else if (shr[c] < OUT_MIN) col_nxt[c] = OUT_MIN[PW-1:0];
      else                       col_nxt[c] = shr[c][PW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // control next state
  // ---------------------------------------------------------------------------
  always_comb begin
    hold_vld_nxt = hold_vld_r;
    row_cnt_nxt  = row_cnt_r;
    if (in_acc) begin
      hold_vld_nxt = 1'b1;
      row_cnt_nxt  = '0;
    end else if (issue) begin
      row_cnt_nxt = row_cnt_r + 1'b1;
      if (row_cnt_r == ROW_POS) hold_vld_nxt = 1'b0;
    end
    s1_vld_nxt = s1_ld ? hold_vld_r : s1_vld_r;
    s2_vld_nxt = s2_ld ? s1_vld_r   : s2_vld_r;
    s3_vld_nxt = s3_ld ? s2_vld_r   : s3_vld_r;
    o_vld_nxt  = o_ld  ? s3_vld_r   : o_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      row_cnt_r  <= '0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
      o_vld_r    <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      row_cnt_r  <= row_cnt_nxt;
      s1_vld_r   <= s1_vld_nxt;
      s2_vld_r   <= s2_vld_nxt;
      s3_vld_r   <= s3_vld_nxt;
      o_vld_r    <= o_vld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      h_pos_r[0] <= in_pos_x;
      h_pos_r[1] <= in_pos_y;
      h_pos_r[2] <= in_pos_z;
      h_qx_r     <= in_quat_x;
      h_qy_r     <= in_quat_y;
      h_qz_r     <= in_quat_z;
      h_qw_r     <= in_quat_w;
      h_sc_r[0]  <= in_scale_x;
      h_sc_r[1]  <= in_scale_y;
      h_sc_r[2]  <= in_scale_z;
      h_be_r     <= in_batch_end;
    end
    if (s1_ld) begin
      s1_row_r <= row_cnt_r;
      s1_sc_r  <= sel_sc;
      s1_be_r  <= h_be_r;
      for (int c = 0; c < NCOL; c++) begin
        s1_p_r[c]  <= (row_cnt_r == ROW_POS) ? h_pos_r[c] : prod_p[c];
        s1_q_r[c]  <= prod_q[c];
        s1_op_r[c] <= sel_op[c];
      end
    end
    if (s2_ld) begin
      s2_row_r <= s1_row_r;
      s2_sc_r  <= s1_sc_r;
      s2_be_r  <= s1_be_r;
      for (int c = 0; c < NCOL; c++) s2_m_r[c] <= m_nxt[c];
    end
    if (s3_ld) begin
      s3_row_r <= s2_row_r;
      s3_be_r  <= s2_be_r;
      for (int c = 0; c < NCOL; c++) s3_s_r[c] <= s_nxt[c];
    end
    if (o_ld) begin
      o_row_r <= s3_row_r;
      o_be_r  <= s3_be_r;
      for (int c = 0; c < NCOL; c++) o_col_r[c] <= col_nxt[c];
    end
  end

  // ---------------------------------------------------------------------------
  // result port
  // ---------------------------------------------------------------------------
  assign out_valid       = o_vld_r;
  assign out_row_index   = o_row_r;
  assign out_col0        = o_col_r[0];
  assign out_col1        = o_col_r[1];
  assign out_col2        = o_col_r[2];
  assign out_col3        = (o_row_r == ROW_POS) ? ONE_Q16 : '0;
  assign out_matrix_done = (o_row_r == ROW_POS);
  assign out_batch_done  = (o_row_r == ROW_POS) && o_be_r;

endmodule
